// ----- sv/tmt_pkg.sv -----
// Shared types and constants for the tabu move table.
`default_nettype none

package tmt_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 64;

	localparam int unsigned CITY_W     = 10;
	localparam int unsigned COUNT_W    = 10;
	localparam int unsigned CAP_W      = 7;
	localparam int unsigned TEN_W      = 10;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned OCC_W      = 7;
	localparam int unsigned SEL_W      = 10;
	localparam int unsigned SCAN_W     = 16;
	localparam int unsigned SCAN_IDX_W = 4;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;
	localparam logic [TEN_W-1:0] TENURE_RST   = 10'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TENURE   = 1'b1;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_BAD_POS = 1'b1;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [CITY_W-1:0] first_city;
		logic [CITY_W-1:0] second_city;
		logic [POS_W-1:0]  position;
	} request_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
		logic [OCC_W-1:0] occupancy;
		logic             status;
	} result_t;

	typedef struct packed {
		logic [CITY_W-1:0]  first;
		logic [CITY_W-1:0]  second;
		logic [COUNT_W-1:0] countdown;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_WRITE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [SEL_W-1:0] sel;
		entry_t           entry;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_INSERT,
		ST_REMOVE,
		ST_TICK,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

// ----- sv/tmt_cell.sv -----
// One table slot: holds an entry, shifts from its right neighbor, compares against the key.
`default_nettype none

module tmt_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic               clk,
	input  tmt_pkg::cell_cmd_t cmd,
	input  tmt_pkg::entry_t    right,
	output tmt_pkg::entry_t    data,
	output logic               match
);
	import tmt_pkg::*;

	localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

	entry_t data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_SHIFT: begin
				if (MY_IDX >= cmd.sel) begin
					data_q <= right;
				end
			end
			CELL_WRITE: begin
				if (MY_IDX == cmd.sel) begin
					data_q <= cmd.entry;
				end
			end
			CELL_ROTATE: begin
				// the slot at sel takes the entry coming back around, the rest move left
				if (MY_IDX == cmd.sel) begin
					data_q <= cmd.entry;
				end else begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data  = data_q;
	assign match = (data_q.first == cmd.entry.first) && (data_q.second == cmd.entry.second);

endmodule

`default_nettype wire

// ----- sv/tmt_find.sv -----
// First-hit search over one group of cell match bits per cycle.
`default_nettype none

module tmt_find #(
	parameter int unsigned ENTRIES = 64,
	localparam int unsigned GROUPS = (ENTRIES + tmt_pkg::SCAN_W - 1) / tmt_pkg::SCAN_W,
	localparam int unsigned GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
	input  logic [ENTRIES-1:0]        hits,
	input  logic [GW-1:0]             grp,
	output logic                      hit,
	output logic [tmt_pkg::SEL_W-1:0] index
);
	import tmt_pkg::*;

	logic [GROUPS*SCAN_W-1:0] padded;
	logic [SCAN_W-1:0]        slice;
	logic [SCAN_IDX_W-1:0]    local_idx;

	assign padded = (GROUPS*SCAN_W)'(hits);
	assign slice  = padded[grp*SCAN_W +: SCAN_W];

	always_comb begin
		local_idx = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (slice[i]) begin
				local_idx = SCAN_IDX_W'(i);
			end
		end
	end

	assign hit   = |slice;
	assign index = SEL_W'({grp, local_idx});

endmodule

`default_nettype wire

// ----- sv/tabu_move_table_unit.sv -----
// Lookup scans the match groups in turn, insert evicts the oldest until one fits,
// tick passes every entry once through slot zero; survivors go back to the tail.
// One request at a time: the next one is taken the cycle after its result is registered.
// Lookup pace is set by the 16-bit group search; tick pace by the one-slot rotation.
// Reset clears occupancy and sets capacity 64, tenure 10; slot contents are not reset.
`default_nettype none

module tabu_move_table_unit #(
	parameter int unsigned MAX_ENTRIES = tmt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           request_valid,
	output logic                           request_stall,
	input  tmt_pkg::request_t              request,
	output logic                           result_valid,
	input  logic                           result_stall,
	output tmt_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tmt_pkg::*;

	localparam int unsigned CW     = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned GROUPS = (MAX_ENTRIES + SCAN_W - 1) / SCAN_W;
	localparam int unsigned GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int unsigned CMP_W  = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     iter_q, iter_d;
	logic [GW-1:0]     grp_q, grp_d;
	logic              found_q, found_d;
	logic [POS_W-1:0]  match_q, match_d;
	logic              status_q, status_d;
	logic [CAP_W-1:0]  cap_q;
	logic [TEN_W-1:0]  tenure_q;
	logic [CITY_W-1:0] first_q;
	logic [CITY_W-1:0] second_q;
	logic [POS_W-1:0]  pos_q;
	logic              result_valid_q;
	result_t           result_q;

	cell_cmd_t          cmd;
	entry_t             cell_data [0:MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match_vec;
	logic [MAX_ENTRIES-1:0] hits;
	logic               find_hit;
	logic [SEL_W-1:0]   find_idx;
	logic [CW-1:0]      eff_cap;
	logic [COUNT_W-1:0] dec;
	logic               out_free;

	// row of cells, each fed by its right neighbor
	assign cell_data[MAX_ENTRIES] = '0;

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		tmt_cell #(
			.IDX(k)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.right(cell_data[k+1]),
			.data (cell_data[k]),
			.match(match_vec[k])
		);
		assign hits[k] = match_vec[k] & (CW'(k) < count_q);
	end

	tmt_find #(
		.ENTRIES(MAX_ENTRIES)
	) u_find (
		.hits (hits),
		.grp  (grp_q),
		.hit  (find_hit),
		.index(find_idx)
	);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (32'(cap_q) > MAX_ENTRIES) begin
			eff_cap = CW'(MAX_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign dec      = cell_data[0].countdown - 1'b1;
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		iter_d    = iter_q;
		grp_d     = grp_q;
		found_d   = found_q;
		match_d   = match_q;
		status_d  = status_q;
		cmd.op    = CELL_HOLD;
		cmd.sel   = '0;
		cmd.entry = '{first: first_q, second: second_q, countdown: tenure_q};
		case (state_q)
			ST_IDLE: begin
				if (request_valid) begin
					found_d  = 1'b0;
					match_d  = '0;
					status_d = STATUS_DONE;
					grp_d    = '0;
					iter_d   = count_q;
					case (request.mode)
						MODE_LOOKUP: state_d = ST_LOOKUP;
						MODE_INSERT: state_d = ST_INSERT;
						MODE_REMOVE: state_d = ST_REMOVE;
						default:     state_d = ST_TICK;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (find_hit) begin
					found_d = 1'b1;
					match_d = find_idx[POS_W-1:0];
					state_d = ST_RESULT;
				end else if (grp_q == GW'(GROUPS - 1)) begin
					state_d = ST_RESULT;
				end else begin
					grp_d = grp_q + 1'b1;
				end
			end
			ST_INSERT: begin
				if (count_q >= eff_cap) begin
					// evict oldest, repeat until a slot is free under capacity
					cmd.op  = CELL_SHIFT;
					count_d = count_q - 1'b1;
				end else begin
					cmd.op  = CELL_WRITE;
					cmd.sel = SEL_W'(count_q);
					count_d = count_q + 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_REMOVE: begin
				if (CMP_W'(pos_q) < CMP_W'(count_q)) begin
					cmd.op  = CELL_SHIFT;
					cmd.sel = SEL_W'(pos_q);
					count_d = count_q - 1'b1;
				end else begin
					status_d = STATUS_BAD_POS;
				end
				state_d = ST_RESULT;
			end
			ST_TICK: begin
				if (iter_q == '0) begin
					state_d = ST_RESULT;
				end else begin
					iter_d = iter_q - 1'b1;
					if (dec != '0) begin
						// survivor goes back in at the tail, order kept
						cmd.op    = CELL_ROTATE;
						cmd.sel   = SEL_W'(count_q - 1'b1);
						cmd.entry = '{first: cell_data[0].first,
							second: cell_data[0].second, countdown: dec};
					end else begin
						cmd.op  = CELL_SHIFT;
						count_d = count_q - 1'b1;
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			iter_q   <= '0;
			grp_q    <= '0;
			found_q  <= 1'b0;
			match_q  <= '0;
			status_q <= STATUS_DONE;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			iter_q   <= iter_d;
			grp_q    <= grp_d;
			found_q  <= found_d;
			match_q  <= match_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && request_valid) begin
			first_q  <= request.first_city;
			second_q <= request.second_city;
			pos_q    <= request.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAPACITY_RST;
			tenure_q <= TENURE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAPACITY: cap_q    <= cfg_data[CAP_W-1:0];
				CFG_TENURE:   tenure_q <= cfg_data[TEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			result_q.found          <= found_q;
			result_q.match_position <= match_q;
			result_q.occupancy      <= OCC_W'(count_q);
			result_q.status         <= status_q;
		end
	end

	assign request_stall = (state_q != ST_IDLE);
	assign result_valid  = result_valid_q;
	assign result        = result_q;
	assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the tabu move table: directed and random requests.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tmt_pkg::*;

	localparam int unsigned DEPTH = MAX_ENTRIES_DEF;

	logic clk;
	logic arst_n = 1'b0;

	logic                 request_valid = 1'b0;
	logic                 request_stall;
	request_t             request = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the table and its registers
	entry_t             shadow_moves [DEPTH];
	int unsigned        shadow_count = 0;
	logic [CAP_W-1:0]   shadow_capacity = CAPACITY_RST;
	logic [TEN_W-1:0]   shadow_tenure = TENURE_RST;

	result_t pending_results [$];
	int      mismatch_count = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      hold_req = 0;

	tabu_move_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic void drop_slot(input int unsigned slot);
		int unsigned k;
		for (k = slot; k + 1 < shadow_count; k++)
			shadow_moves[k] = shadow_moves[k + 1];
		shadow_count--;
	endfunction

	function automatic result_t apply_move(input request_t r);
		result_t            res;
		int unsigned        cap;
		int unsigned        k;
		int unsigned        w;
		logic [COUNT_W-1:0] left;
		res = '0;
		case (r.mode)
			MODE_LOOKUP: begin
				for (k = 0; k < shadow_count; k++) begin
					if (!res.found && shadow_moves[k].first == r.first_city &&
							shadow_moves[k].second == r.second_city) begin
						res.found = 1'b1;
						res.match_position = POS_W'(k);
					end
				end
			end
			MODE_INSERT: begin
				cap = shadow_capacity;
				if (cap == 0) cap = 1;
				if (cap > DEPTH) cap = DEPTH;
				while (shadow_count >= cap) drop_slot(0);
				shadow_moves[shadow_count].first = r.first_city;
				shadow_moves[shadow_count].second = r.second_city;
				shadow_moves[shadow_count].countdown = shadow_tenure;
				shadow_count++;
			end
			MODE_REMOVE: begin
				if (r.position < shadow_count) drop_slot(r.position);
				else res.status = STATUS_BAD_POS;
			end
			default: begin
				// age every entry, compact the survivors in order
				w = 0;
				for (k = 0; k < shadow_count; k++) begin
					left = shadow_moves[k].countdown - 1'b1;
					if (left != '0) begin
						shadow_moves[w] = shadow_moves[k];
						shadow_moves[w].countdown = left;
						w++;
					end
				end
				shadow_count = w;
			end
		endcase
		res.occupancy = OCC_W'(shadow_count);
		return res;
	endfunction

	function automatic request_t make_move(input mode_t m, input int unsigned a,
			input int unsigned b, input int unsigned p);
		request_t r;
		r.mode = m;
		r.first_city = CITY_W'(a);
		r.second_city = CITY_W'(b);
		r.position = POS_W'(p);
		return r;
	endfunction

	function automatic request_t random_move();
		request_t    r;
		int unsigned pick;
		entry_t      e;
		pick = $urandom_range(99);
		r.mode = pick < 35 ? MODE_LOOKUP : pick < 70 ? MODE_INSERT :
			pick < 85 ? MODE_REMOVE : MODE_TICK;
		r.first_city = CITY_W'($urandom_range(1023));
		r.second_city = CITY_W'($urandom_range(1023));
		r.position = POS_W'($urandom_range(63));
		// a small city pool gives duplicate moves and lookup hits
		if ($urandom_range(1) == 1) begin
			r.first_city = CITY_W'($urandom_range(3));
			r.second_city = CITY_W'($urandom_range(3));
		end
		if (r.mode == MODE_LOOKUP && shadow_count != 0 && $urandom_range(99) < 60) begin
			e = shadow_moves[$urandom_range(shadow_count - 1)];
			r.first_city = e.first;
			r.second_city = e.second;
		end
		if (r.mode == MODE_REMOVE && shadow_count != 0 && $urandom_range(99) < 80)
			r.position = POS_W'($urandom_range(shadow_count - 1));
		return r;
	endfunction

	// expectation for every accepted request
	always @(posedge clk) begin
		if (arst_n && request_valid && !request_stall)
			pending_results.push_back(apply_move(request));
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %p", result);
			end else begin
				want = pending_results.pop_front();
				if (result.found !== want.found ||
						result.match_position !== want.match_position ||
						result.occupancy !== want.occupancy ||
						result.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch exp/got: found %0d/%0d pos %0d/%0d occ %0d/%0d status %0d/%0d",
							want.found, result.found, want.match_position,
							result.match_position, want.occupancy, result.occupancy,
							want.status, result.status);
				end
			end
		end
	end

	// receiver: random stalls, plus long hold-offs on demand
	always @(posedge clk) begin
		int hold_left;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_move(input request_t r);
		while ($urandom_range(99) < idle_pct) begin
			request_valid <= 1'b0;
			@(posedge clk);
		end
		request <= r;
		request_valid <= 1'b1;
		do @(posedge clk); while (request_stall);
	endtask

	task automatic wait_idle();
		request_valid <= 1'b0;
		// let the last accepted request be queued before the check
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_registers(input logic [CFG_DATA_W-1:0] cap_data,
			input logic [CFG_DATA_W-1:0] ten_data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_data <= cap_data;
		do @(posedge clk); while (!cfg_ready);
		shadow_capacity = cap_data[CAP_W-1:0];
		cfg_index <= CFG_TENURE;
		cfg_data <= ten_data;
		do @(posedge clk); while (!cfg_ready);
		shadow_tenure = ten_data[TEN_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic test_basic_moves();
		send_move(make_move(MODE_LOOKUP, 5, 6, 0));
		send_move(make_move(MODE_REMOVE, 0, 0, 0));
		send_move(make_move(MODE_TICK, 0, 0, 0));
		send_move(make_move(MODE_INSERT, 0, 0, 0));
		send_move(make_move(MODE_INSERT, 1023, 1023, 63));
		send_move(make_move(MODE_INSERT, 'h2AA, 'h155, 0));
		send_move(make_move(MODE_INSERT, 'h155, 'h2AA, 0));
		send_move(make_move(MODE_INSERT, 0, 0, 0));
		send_move(make_move(MODE_LOOKUP, 1023, 1023, 0));
		send_move(make_move(MODE_LOOKUP, 'h155, 'h2AA, 63));
		send_move(make_move(MODE_LOOKUP, 0, 0, 0));
		send_move(make_move(MODE_LOOKUP, 1023, 0, 0));
		send_move(make_move(MODE_LOOKUP, 0, 1023, 0));
		send_move(make_move(MODE_REMOVE, 1023, 1023, 63));
		send_move(make_move(MODE_REMOVE, 0, 0, 5));
		send_move(make_move(MODE_REMOVE, 0, 0, 4));
		send_move(make_move(MODE_REMOVE, 0, 0, 1));
		send_move(make_move(MODE_LOOKUP, 'h2AA, 'h155, 0));
		send_move(make_move(MODE_TICK, 1023, 1023, 63));
		send_move(make_move(MODE_TICK, 0, 0, 0));
	endtask

	task automatic test_capacity_limits();
		int i;
		// 127 is clamped to the table depth
		set_registers(10'h07F, 10'd10);
		for (i = 100; i < 166; i++)
			send_move(make_move(MODE_INSERT, i, 1023 - i, 0));
		send_move(make_move(MODE_LOOKUP, 165, 1023 - 165, 0));
		send_move(make_move(MODE_LOOKUP, 100, 1023 - 100, 0));
		send_move(make_move(MODE_LOOKUP, 102, 1023 - 102, 0));
		send_move(make_move(MODE_REMOVE, 0, 0, 63));
		send_move(make_move(MODE_REMOVE, 0, 0, 0));
		send_move(make_move(MODE_TICK, 0, 0, 0));
		// capacity lowered under the occupancy: next insert trims the oldest
		set_registers(10'd3, 10'd10);
		send_move(make_move(MODE_INSERT, 7, 8, 0));
		send_move(make_move(MODE_LOOKUP, 7, 8, 0));
		set_registers(10'd0, 10'd10);
		send_move(make_move(MODE_INSERT, 9, 10, 0));
		send_move(make_move(MODE_INSERT, 11, 12, 0));
		// upper data bits are dropped: 0x45 is above the depth
		set_registers(10'h3C5, 10'd10);
		send_move(make_move(MODE_INSERT, 13, 14, 0));
		send_move(make_move(MODE_LOOKUP, 13, 14, 0));
	endtask

	task automatic test_tenure_expiry();
		set_registers(10'd64, 10'd1);
		send_move(make_move(MODE_INSERT, 1, 2, 0));
		set_registers(10'd64, 10'd2);
		send_move(make_move(MODE_INSERT, 3, 4, 0));
		// zero tenure wraps on the first tick
		set_registers(10'd64, 10'd0);
		send_move(make_move(MODE_INSERT, 5, 6, 0));
		set_registers(10'd64, 10'd1);
		send_move(make_move(MODE_INSERT, 7, 8, 0));
		send_move(make_move(MODE_TICK, 0, 0, 0));
		send_move(make_move(MODE_LOOKUP, 5, 6, 0));
		send_move(make_move(MODE_TICK, 0, 0, 0));
		send_move(make_move(MODE_LOOKUP, 5, 6, 0));
		set_registers(10'd64, 10'd1023);
		send_move(make_move(MODE_INSERT, 1023, 0, 0));
		send_move(make_move(MODE_TICK, 0, 0, 0));
		send_move(make_move(MODE_LOOKUP, 1023, 0, 0));
	endtask

	task automatic test_backpressure();
		int i;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 300;
		for (i = 0; i < 16; i++)
			send_move(random_move());
	endtask

	task automatic test_random_traffic(input int count, input int idle_p, input int stall_p,
			input logic [CFG_DATA_W-1:0] cap_data, input logic [CFG_DATA_W-1:0] ten_data);
		int i;
		set_registers(cap_data, ten_data);
		idle_pct = idle_p;
		stall_pct = stall_p;
		for (i = 0; i < count; i++)
			send_move(random_move());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_moves();
		test_capacity_limits();
		test_tenure_expiry();
		test_backpressure();
		test_random_traffic(160, 0, 0, 10'd8, 10'd12);
		test_random_traffic(160, 66, 0, 10'd64, 10'd1023);
		test_random_traffic(160, 0, 66, 10'd1, 10'd1);
		test_random_traffic(160, 35, 35, 10'd16, 10'd5);
		test_random_traffic(100, 0, 0, 10'd33, 10'd0);
		wait_idle();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
